// File: design/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants of the packet airtime calculator
// Register indexes, fixed arithmetic constants and the reciprocal table used
// for the payload symbol ceiling division.
// ----------------------------------------------------------------------------
`default_nettype none
package pat_pkg;

  typedef enum logic [2:0] {
    REG_HEADER_ON = 3'd0,
    REG_SF_CODE   = 3'd1,
    REG_BW_HZ     = 3'd2,
    REG_CR_CODE   = 3'd3,
    REG_PREAMBLE  = 3'd4,
    REG_CRC_ON    = 3'd5,
    REG_FIXED_LEN = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgW       = 19;
  localparam int unsigned BwMin      = 7800;
  localparam int unsigned BwMax      = 500000;
  localparam int unsigned LdroLimit  = 16001;   // sym_us > 16000
  localparam int unsigned UsecPerSec = 1000000;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned NumW       = 51;      // dividend width
  localparam int unsigned DivW       = 21;      // divisor width (4*bw)
  localparam int unsigned LatCycles  = 5 + NumW + 1;

  // ceil(2^16 / k) for k in 4..12
  function automatic logic [14:0] recip(input logic [3:0] k);
    logic [14:0] r;
    case (k)
      4'd4:    r = 15'd16384;
      4'd5:    r = 15'd13108;
      4'd6:    r = 15'd10923;
      4'd7:    r = 15'd9363;
      4'd8:    r = 15'd8192;
      4'd9:    r = 15'd7282;
      4'd10:   r = 15'd6554;
      4'd11:   r = 15'd5958;
      4'd12:   r = 15'd5462;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/packet_airtime_calculator.sv
// ----------------------------------------------------------------------------
// packet_airtime_calculator: time on air of a chirp spread spectrum packet
// Fully pipelined: one item accepted every cycle.
// Depth is set by the restoring divider, one quotient bit per stage (51).
// busy_o is always low; results come out on done_o for one cycle each.
// Reset clears the valid bits and loads the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module packet_airtime_calculator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [7:0]                 payload_bytes_i,
  output logic                            done_o,
  output logic [31:0]                     airtime_usec_o,
  output logic                            saturated_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [2:0]                 cfg_idx_i,
  input  wire logic [pat_pkg::CfgW-1:0]   cfg_wdata_i
);

  localparam int unsigned NW = pat_pkg::NumW;
  localparam int unsigned DW = pat_pkg::DivW;

  // configuration
  logic        header_on_q;
  logic [2:0]  sf_code_q;
  logic [18:0] bw_hz_q;
  logic [1:0]  cr_code_q;
  logic [15:0] preamble_q;
  logic        crc_on_q;
  logic [7:0]  fixed_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_on_q <= 1'b1;
      sf_code_q   <= 3'd1;
      bw_hz_q     <= 19'd125000;
      cr_code_q   <= 2'd0;
      preamble_q  <= 16'd8;
      crc_on_q    <= 1'b1;
      fixed_len_q <= 8'd64;
    end else if (cfg_we_i) begin
      unique case (pat_pkg::reg_idx_e'(cfg_idx_i))
        pat_pkg::REG_HEADER_ON: header_on_q <= cfg_wdata_i[0];
        pat_pkg::REG_SF_CODE:   sf_code_q   <= cfg_wdata_i[2:0];
        pat_pkg::REG_BW_HZ:     bw_hz_q     <= cfg_wdata_i[18:0];
        pat_pkg::REG_CR_CODE:   cr_code_q   <= cfg_wdata_i[1:0];
        pat_pkg::REG_PREAMBLE:  preamble_q  <= cfg_wdata_i[15:0];
        pat_pkg::REG_CRC_ON:    crc_on_q    <= cfg_wdata_i[0];
        pat_pkg::REG_FIXED_LEN: fixed_len_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // settings from cfg: user keeps stable with items in flight; unchecked
  logic [3:0]    sf;
  logic [18:0]   bw;
  logic [DW-1:0] divisor;

  always_comb begin
    sf = (sf_code_q > 3'd6) ? 4'd12 : {1'b0, sf_code_q} + 4'd6;
    if (bw_hz_q < 19'(pat_pkg::BwMin)) begin
      bw = 19'(pat_pkg::BwMin);
    end else if (bw_hz_q > 19'(pat_pkg::BwMax)) begin
      bw = 19'(pat_pkg::BwMax);
    end else begin
      bw = bw_hz_q;
    end
    divisor = {bw, 2'b00};
  end

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i && !busy_o;

  // stage 1: payload numerator / 4 and LDRO threshold product
  logic               v1_q;
  logic signed [10:0] m1_q;
  logic [33:0]        lim1_q;
  logic [7:0]         pl;

  assign pl = header_on_q ? payload_bytes_i : fixed_len_q;

  always_ff @(posedge clk_i) begin
    m1_q   <= $signed({2'b00, pl, 1'b0}) - $signed({7'd0, sf}) + 11'sd7
              + (crc_on_q ? 11'sd4 : 11'sd0) - (header_on_q ? 11'sd0 : 11'sd5);
    lim1_q <= 34'(bw) * 34'(pat_pkg::LdroLimit);
  end

  // stage 2: LDRO decision, symbol divisor, ceiling bias
  logic        v2_q;
  logic        pos2_q;
  logic [3:0]  k2_q;
  logic [9:0]  x2_q;
  logic [33:0] sym_num;
  logic        ldro;
  logic [3:0]  k;

  always_comb begin
    sym_num = 34'(pat_pkg::UsecPerSec) << sf;
    ldro    = sym_num >= lim1_q;
    k       = ldro ? sf - 4'd2 : sf;
  end

  always_ff @(posedge clk_i) begin
    pos2_q <= m1_q > 11'sd0;
    k2_q   <= k;
    x2_q   <= m1_q[9:0] + {6'd0, k} - 10'd1;
  end

  // stage 3: ceiling quotient by reciprocal multiply
  logic       v3_q;
  logic       pos3_q;
  logic [7:0] q3_q;
  logic [24:0] prod;

  assign prod = 25'(x2_q) * 25'(pat_pkg::recip(k2_q));

  always_ff @(posedge clk_i) begin
    pos3_q <= pos2_q;
    q3_q   <= prod[pat_pkg::RecipShift +: 8];
  end

  // stage 4: quarter symbol count
  logic        v4_q;
  logic [18:0] qs4_q;
  logic [10:0] pay;

  assign pay = pos3_q ? 11'(q3_q) * 11'({2'b00, cr_code_q} + 4'd5) + 11'd8 : 11'd8;

  always_ff @(posedge clk_i) begin
    qs4_q <= {(17'(pay) + 17'(preamble_q)), 2'b00} + 19'd17;
  end

  // stage 5: scale to microseconds
  logic        v5_q;
  logic [38:0] n5_q;

  always_ff @(posedge clk_i) begin
    n5_q <= 39'(qs4_q) * 39'(pat_pkg::UsecPerSec);
  end

  // divider: stage 0 loads the dividend, stages 1..NW each retire one bit
  logic [NW:0]   dv_q;
  logic [NW-1:0] num_q [NW+1];
  logic [DW-1:0] rem_q [NW+1];
  logic [31:0]   quo_q [NW+1];
  logic          ovf_q [NW+1];
  logic [DW:0]   trial [NW+1];
  logic          ge    [NW+1];

  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int i = 1; i <= NW; i++) begin
      trial[i] = {rem_q[i-1], num_q[i-1][NW-1]};
      ge[i]    = trial[i] >= {1'b0, divisor};
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= NW'(n5_q) << sf;
    rem_q[0] <= '0;
    quo_q[0] <= '0;
    ovf_q[0] <= 1'b0;
    for (int i = 1; i <= NW; i++) begin
      num_q[i] <= {num_q[i-1][NW-2:0], 1'b0};
      rem_q[i] <= ge[i] ? DW'(trial[i] - {1'b0, divisor}) : trial[i][DW-1:0];
      quo_q[i] <= {quo_q[i-1][30:0], ge[i]};
      ovf_q[i] <= ovf_q[i-1] | quo_q[i-1][31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      dv_q <= '0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      dv_q <= {dv_q[NW-1:0], v5_q};
    end
  end

  assign done_o         = dv_q[NW];
  assign saturated_o    = ovf_q[NW];
  assign airtime_usec_o = ovf_q[NW] ? 32'hFFFF_FFFF : quo_q[NW];

`ifndef NO_ASSERTIONS
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |-> airtime_usec_o == 32'hFFFF_FFFF)
    else $error("saturated result not all ones");

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, pat_pkg::LatCycles))
    else $error("result without a started item");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[NW] |-> rem_q[NW] < divisor)
    else $error("divider remainder out of range");
`endif

endmodule
`default_nettype wire
